FILE: rtl/core/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants of the sorted priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

    // fixed field widths of the ports
    localparam int unsigned FIELD_W  = 16;
    localparam int unsigned SIZE_W   = 5;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned ACTION_W = 3;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT      = 3'd0,
        ACT_CHANGE      = 3'd1,
        ACT_REMOVE_HEAD = 3'd2,
        ACT_REMOVE_ELEM = 3'd3,
        ACT_CLEAR       = 3'd4,
        ACT_CONTAINS    = 3'd5,
        ACT_READ_FIRST  = 3'd6,
        ACT_READ_NEXT   = 3'd7
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK        = 2'd0,
        STS_NOT_FOUND = 2'd1,
        STS_FULL      = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_REMOVE = 2'd2
    } t_cell_op;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_EXEC   = 2'd1,
        ST_INSERT = 2'd2
    } t_state;

    // command broadcast to every cell of the row
    typedef struct packed {
        t_cell_op op;
        logic     use_prio;   // match also needs priority equality
    } t_cell_ctl;

endpackage

`default_nettype wire

FILE: rtl/core/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted row: holds an (id, priority) entry, compares it with
// the broadcast key and shifts in from either neighbour on insert or remove.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell #(
    parameter int unsigned IDX        = 0,
    parameter int unsigned CNT_W      = 5,
    parameter int unsigned ID_WIDTH   = 16,
    parameter int unsigned PRIO_WIDTH = 16
) (
    input  wire                        i_clk,
    input  wire spq_pkg::t_cell_ctl    i_ctl,
    input  wire [CNT_W-1:0]            i_count,
    input  wire [ID_WIDTH-1:0]         i_key_id,
    input  wire [PRIO_WIDTH-1:0]       i_key_prio,
    input  wire                        i_left_ge,
    input  wire [ID_WIDTH-1:0]         i_left_id,
    input  wire [PRIO_WIDTH-1:0]       i_left_prio,
    input  wire [ID_WIDTH-1:0]         i_right_id,
    input  wire [PRIO_WIDTH-1:0]       i_right_prio,
    input  wire                        i_seen,
    output logic                       o_ge,
    output logic                       o_seen,
    output logic [ID_WIDTH-1:0]        o_id,
    output logic [PRIO_WIDTH-1:0]      o_prio
);

    logic [ID_WIDTH-1:0]   r_id;
    logic [PRIO_WIDTH-1:0] r_prio;
    logic [ID_WIDTH-1:0]   n_id;
    logic [PRIO_WIDTH-1:0] n_prio;
    logic                  w_occupied;
    logic                  w_match;

    assign w_occupied = CNT_W'(IDX) < i_count;
    // occupied entries are sorted descending, so ge is true over a prefix
    assign o_ge       = w_occupied && (r_prio >= i_key_prio);
    assign w_match    = w_occupied && (r_id == i_key_id)
                        && (!i_ctl.use_prio || (r_prio == i_key_prio));
    // seen: the first match lies at or before this slot
    assign o_seen     = i_seen || w_match;
    assign o_id       = r_id;
    assign o_prio     = r_prio;

    always_comb begin
        n_id   = r_id;
        n_prio = r_prio;
        case (i_ctl.op)
            spq_pkg::CELL_INSERT: begin
                if (!o_ge) begin
                    if (i_left_ge) begin
                        n_id   = i_key_id;
                        n_prio = i_key_prio;
                    end else begin
                        n_id   = i_left_id;
                        n_prio = i_left_prio;
                    end
                end
            end
            spq_pkg::CELL_REMOVE: begin
                if (o_seen) begin
                    n_id   = i_right_id;
                    n_prio = i_right_prio;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_id   <= n_id;
        r_prio <= n_prio;
    end

endmodule

`default_nettype wire

FILE: rtl/core/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Priority queue kept as a row of cells sorted by descending priority, equal
// priorities in arrival order, with a read cursor over the row.
//
// channel  direction  handshake                 word
// in       sink       i_in_valid / o_in_ready   action, element id, priorities
// out      source     o_out_valid / i_out_ready status, size, found, read data
//
// An action is accepted, then every cell compares and shifts together in one
// pass of the cell row; a change of priority that finds its entry takes a
// further pass, as the removal and the reinsertion each need one.
// The next word is taken no earlier than the edge at which the result leaves
// the output register. Reset empties the queue and sets the cursor to zero;
// a stalled output holds the result and keeps the input closed.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_priority_queue #(
    parameter int unsigned DEPTH      = 16,
    parameter int unsigned ID_WIDTH   = 16,
    parameter int unsigned PRIO_WIDTH = 16
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_in_valid,
    output logic                                o_in_ready,
    input  wire  [spq_pkg::ACTION_W-1:0]        i_action,
    input  wire  [spq_pkg::FIELD_W-1:0]         i_element_id,
    input  wire  [spq_pkg::FIELD_W-1:0]         i_priority_req,
    input  wire  [spq_pkg::FIELD_W-1:0]         i_new_priority,
    output logic                                o_out_valid,
    input  wire                                 i_out_ready,
    output logic [spq_pkg::STATUS_W-1:0]        o_status,
    output logic [spq_pkg::SIZE_W-1:0]          o_size,
    output logic                                o_found,
    output logic                                o_read_valid,
    output logic [spq_pkg::FIELD_W-1:0]         o_read_element,
    output logic [spq_pkg::FIELD_W-1:0]         o_read_priority
);

    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam int unsigned IDX_W = $clog2(DEPTH);

    // request register
    spq_pkg::t_action      r_action;
    logic [ID_WIDTH-1:0]   r_id;
    logic [PRIO_WIDTH-1:0] r_prio;
    logic [PRIO_WIDTH-1:0] r_nprio;

    spq_pkg::t_state       r_state, n_state;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [CNT_W-1:0]      r_cursor, n_cursor;

    // output register
    logic                  r_out_valid, n_out_valid;
    spq_pkg::t_status      r_status, n_status;
    logic [CNT_W-1:0]      r_size, n_size;
    logic                  r_found, n_found;
    logic                  r_rvalid, n_rvalid;
    logic [ID_WIDTH-1:0]   r_rid, n_rid;
    logic [PRIO_WIDTH-1:0] r_rprio, n_rprio;

    // cell row
    spq_pkg::t_cell_ctl    w_ctl;
    logic [PRIO_WIDTH-1:0] w_key_prio;
    logic                  w_head;
    logic                  w_accept;
    logic                  w_load;
    logic                  w_found;
    logic                  w_ge   [DEPTH];
    logic                  w_seen [DEPTH];
    logic [ID_WIDTH-1:0]   w_id   [DEPTH];
    logic [PRIO_WIDTH-1:0] w_prio [DEPTH];

    assign o_in_ready = (r_state == spq_pkg::ST_IDLE) && (!r_out_valid || i_out_ready);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_found    = w_seen[DEPTH-1];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic                  w_left_ge;
        logic                  w_seen_in;
        logic [ID_WIDTH-1:0]   w_left_id;
        logic [PRIO_WIDTH-1:0] w_left_prio;
        logic [ID_WIDTH-1:0]   w_right_id;
        logic [PRIO_WIDTH-1:0] w_right_prio;

        if (g == 0) begin : g_head
            assign w_left_ge   = 1'b1;
            assign w_seen_in   = w_head;
            assign w_left_id   = r_id;
            assign w_left_prio = w_key_prio;
        end else begin : g_body
            assign w_left_ge   = w_ge[g-1];
            assign w_seen_in   = w_seen[g-1];
            assign w_left_id   = w_id[g-1];
            assign w_left_prio = w_prio[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign w_right_id   = w_id[g];
            assign w_right_prio = w_prio[g];
        end else begin : g_mid
            assign w_right_id   = w_id[g+1];
            assign w_right_prio = w_prio[g+1];
        end

        spq_cell #(
            .IDX        (g),
            .CNT_W      (CNT_W),
            .ID_WIDTH   (ID_WIDTH),
            .PRIO_WIDTH (PRIO_WIDTH)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_count      (r_count),
            .i_key_id     (r_id),
            .i_key_prio   (w_key_prio),
            .i_left_ge    (w_left_ge),
            .i_left_id    (w_left_id),
            .i_left_prio  (w_left_prio),
            .i_right_id   (w_right_id),
            .i_right_prio (w_right_prio),
            .i_seen       (w_seen_in),
            .o_ge         (w_ge[g]),
            .o_seen       (w_seen[g]),
            .o_id         (w_id[g]),
            .o_prio       (w_prio[g])
        );
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_cursor     = r_cursor;
        w_ctl.op     = spq_pkg::CELL_HOLD;
        w_ctl.use_prio = 1'b0;
        w_key_prio   = r_prio;
        w_head       = 1'b0;
        w_load       = 1'b0;
        n_status     = spq_pkg::STS_OK;
        n_found      = 1'b0;
        n_rvalid     = 1'b0;
        n_rid        = '0;
        n_rprio      = '0;

        case (r_state)
            spq_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = spq_pkg::ST_EXEC;
                end
            end
            spq_pkg::ST_EXEC: begin
                w_load  = 1'b1;
                n_state = spq_pkg::ST_IDLE;
                case (r_action)
                    spq_pkg::ACT_INSERT: begin
                        if (r_count == CNT_W'(DEPTH)) begin
                            n_status = spq_pkg::STS_FULL;
                        end else begin
                            w_ctl.op = spq_pkg::CELL_INSERT;
                            n_count  = r_count + 1'b1;
                        end
                    end
                    spq_pkg::ACT_CHANGE: begin
                        if (r_prio != r_nprio) begin
                            w_ctl.op       = spq_pkg::CELL_REMOVE;
                            w_ctl.use_prio = 1'b1;
                            if (w_found) begin
                                // reinsert under the new priority next cycle
                                n_count = r_count - 1'b1;
                                w_load  = 1'b0;
                                n_state = spq_pkg::ST_INSERT;
                            end else begin
                                n_status = spq_pkg::STS_NOT_FOUND;
                            end
                        end
                    end
                    spq_pkg::ACT_REMOVE_HEAD: begin
                        w_ctl.op = spq_pkg::CELL_REMOVE;
                        w_head   = 1'b1;
                        if (r_count != '0) begin
                            n_count = r_count - 1'b1;
                        end
                    end
                    spq_pkg::ACT_REMOVE_ELEM: begin
                        w_ctl.op = spq_pkg::CELL_REMOVE;
                        if (w_found) begin
                            n_count = r_count - 1'b1;
                        end else begin
                            n_status = spq_pkg::STS_NOT_FOUND;
                        end
                    end
                    spq_pkg::ACT_CLEAR: begin
                        n_count = '0;
                    end
                    spq_pkg::ACT_CONTAINS: begin
                        n_found = w_found;
                    end
                    spq_pkg::ACT_READ_FIRST, spq_pkg::ACT_READ_NEXT: begin
                        if (r_action == spq_pkg::ACT_READ_FIRST) begin
                            n_cursor = '0;
                        end else if (r_cursor < CNT_W'(DEPTH)) begin
                            n_cursor = r_cursor + 1'b1;
                        end
                        // count never exceeds DEPTH, so this also bounds the index
                        if (n_cursor < r_count) begin
                            n_rvalid = 1'b1;
                            n_rid    = w_id[n_cursor[IDX_W-1:0]];
                            n_rprio  = w_prio[n_cursor[IDX_W-1:0]];
                        end
                    end
                    default: begin
                    end
                endcase
            end
            spq_pkg::ST_INSERT: begin
                w_ctl.op   = spq_pkg::CELL_INSERT;
                w_key_prio = r_nprio;
                n_count    = r_count + 1'b1;
                w_load     = 1'b1;
                n_state    = spq_pkg::ST_IDLE;
            end
            default: begin
                n_state = spq_pkg::ST_IDLE;
            end
        endcase

        n_size = n_count;
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= spq_pkg::ST_IDLE;
            r_count     <= '0;
            r_cursor    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_cursor    <= n_cursor;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_action <= spq_pkg::t_action'(i_action);
            r_id     <= ID_WIDTH'(i_element_id);
            r_prio   <= PRIO_WIDTH'(i_priority_req);
            r_nprio  <= PRIO_WIDTH'(i_new_priority);
        end
        if (w_load) begin
            r_status <= n_status;
            r_size   <= n_size;
            r_found  <= n_found;
            r_rvalid <= n_rvalid;
            r_rid    <= n_rid;
            r_rprio  <= n_rprio;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_size          = spq_pkg::SIZE_W'(r_size);
    assign o_found         = r_found;
    assign o_read_valid    = r_rvalid;
    assign o_read_element  = spq_pkg::FIELD_W'(r_rid);
    assign o_read_priority = spq_pkg::FIELD_W'(r_rprio);

endmodule

`default_nettype wire
